### rtl/cdss_pkg.sv
// cdss_pkg: shared types, constants and segment fonts for the countdown scanner
// no dependencies; imported by every module of the block

package cdss_pkg;

  localparam int unsigned WASH_W    = 14;
  localparam int unsigned FILL_W    = 12;
  localparam int unsigned RINSE_W   = 14;
  localparam int unsigned SPIN_W    = 14;
  localparam int unsigned TOTAL_W   = 16;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned SEG_W     = 8;
  localparam int unsigned DIGIT_W   = 2;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

  // reciprocals for division of 16-bit values by constants
  localparam logic [16:0] RECIP_10  = 17'd52429;   // >> 19
  localparam logic [16:0] RECIP_60  = 17'd34953;   // >> 21
  localparam logic [16:0] RECIP_600 = 17'd111849;  // >> 26
  localparam logic [15:0] RECIP_6   = 16'd10923;   // >> 16, values below 2^13

  localparam logic [SEG_W-1:0] SEG_DP     = 8'h80;
  localparam logic [SEG_W-1:0] SEG_ZERO_N = 8'hC0;

  typedef enum logic [1:0] {
    REG_WASH  = 2'd0,
    REG_FILL  = 2'd1,
    REG_RINSE = 2'd2,
    REG_SPIN  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    DIG_SEC_ONES = 2'd0,
    DIG_SEC_TENS = 2'd1,
    DIG_MIN_ONES = 2'd2,
    DIG_MIN_TENS = 2'd3
  } digit_t;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_COUNT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    digit_t               digit;
    logic [TOTAL_W-1:0]   value;
  } stage_t;

  function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] val);
    logic [SEG_W-1:0] pat;
    case (val)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h27;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h67;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  // active-low "complete" pattern per digit
  function automatic logic [SEG_W-1:0] done_font_n(input digit_t d);
    logic [SEG_W-1:0] pat;
    case (d)
      DIG_SEC_ONES: pat = 8'hF0;
      DIG_SEC_TENS: pat = 8'hF6;
      DIG_MIN_ONES: pat = 8'hF6;
      DIG_MIN_TENS: pat = 8'hC6;
      default:      pat = 8'hFF;
    endcase
    return pat;
  endfunction

endpackage

### rtl/cdss_if.sv
// cdss_item_if / cdss_result_if: valid-ready channels of the countdown scanner
// depends on cdss_pkg for field widths

interface cdss_item_if
  import cdss_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic                        active;
  logic                        running;
  logic signed [ELAPSED_W-1:0] elapsed_seconds;

  modport source (output valid, active, running, elapsed_seconds, input ready);
  modport sink   (input valid, active, running, elapsed_seconds, output ready);
endinterface

interface cdss_result_if
  import cdss_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit_index;
  logic [SEG_W-1:0]   segments_n;

  modport source (output valid, digit_index, segments_n, input ready);
  modport sink   (input valid, digit_index, segments_n, output ready);
endinterface

### rtl/cdss_cfg.sv
// cdss_cfg: apb register file for phase lengths and the registered program total
// depends on cdss_pkg

module cdss_cfg
  import cdss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  output logic [TOTAL_W-1:0]  total
);

  logic [WASH_W-1:0]  wash_seconds;
  logic [FILL_W-1:0]  fill_seconds;
  logic [RINSE_W-1:0] rinse_seconds;
  logic [SPIN_W-1:0]  spin_seconds;
  logic [TOTAL_W-1:0] total_next;
  logic [TOTAL_W:0]   full_sum;
  logic               wr_en;
  reg_index_t         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wash_seconds  <= '0;
      fill_seconds  <= '0;
      rinse_seconds <= '0;
      spin_seconds  <= '0;
      total         <= '0;
    end else begin
      total <= total_next;
      if (wr_en) begin
        case (reg_sel)
          REG_WASH:  wash_seconds  <= pwdata[WASH_W-1:0];
          REG_FILL:  fill_seconds  <= pwdata[FILL_W-1:0];
          REG_RINSE: rinse_seconds <= pwdata[RINSE_W-1:0];
          REG_SPIN:  spin_seconds  <= pwdata[SPIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    full_sum = {3'b0, wash_seconds} + {3'b0, fill_seconds, 2'b00}
             + {3'b0, rinse_seconds} + {3'b0, spin_seconds};
    if (fill_seconds != '0 && rinse_seconds != '0) begin
      total_next = full_sum[TOTAL_W] ? TOTAL_MAX : full_sum[TOTAL_W-1:0];
    end else begin
      total_next = {2'b0, spin_seconds};
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WASH:  prdata = {{(DATA_W-WASH_W){1'b0}}, wash_seconds};
      REG_FILL:  prdata = {{(DATA_W-FILL_W){1'b0}}, fill_seconds};
      REG_RINSE: prdata = {{(DATA_W-RINSE_W){1'b0}}, rinse_seconds};
      REG_SPIN:  prdata = {{(DATA_W-SPIN_W){1'b0}}, spin_seconds};
      default:   prdata = '0;
    endcase
  end

endmodule

### rtl/cdss_front.sv
// cdss_front: input register, digit pointer and remaining-time subtract
// depends on cdss_pkg and cdss_if

module cdss_front
  import cdss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  cdss_item_if.sink          item,
  input  logic [TOTAL_W-1:0] total,
  output logic               stage_valid,
  input  logic               stage_ready,
  output stage_t             stage
);

  logic [DIGIT_W-1:0] digit_pointer;
  logic               in_valid;
  logic               in_running;
  logic [14:0]        in_raw;
  digit_t             in_digit;
  logic               in_ready;
  logic               in_take;
  logic               shows;
  stage_t             stage_next;

  assign shows      = item.active && !(item.running && item.elapsed_seconds[ELAPSED_W-1]);
  assign in_ready   = !in_valid || !stage_valid || stage_ready;
  assign item.ready = in_ready;
  assign in_take    = item.valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_pointer <= '0;
      in_valid      <= 1'b0;
      stage_valid   <= 1'b0;
    end else begin
      if (in_take && shows) begin
        digit_pointer <= digit_pointer + 2'd1;
      end
      if (!stage_valid || stage_ready) begin
        stage_valid <= in_valid;
      end
      if (in_ready) begin
        in_valid <= in_take && shows;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_running <= item.running;
      in_raw     <= item.elapsed_seconds[14:0];
      in_digit   <= digit_t'(digit_pointer);
    end
    if (!stage_valid || stage_ready) begin
      stage <= stage_next;
    end
  end

  always_comb begin
    stage_next.digit = in_digit;
    stage_next.value = total - {1'b0, in_raw};
    if (!in_running) begin
      stage_next.kind = KIND_ZERO;
    end else if ({1'b0, in_raw} >= total) begin
      stage_next.kind = KIND_DONE;
    end else begin
      stage_next.kind = KIND_COUNT;
    end
  end

endmodule

### rtl/cdss_digit.sv
// cdss_digit: digit extraction by reciprocal multiply, segment decode, result register
// depends on cdss_pkg and cdss_if

module cdss_digit
  import cdss_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          stage_valid,
  output logic          stage_ready,
  input  stage_t        stage,
  cdss_result_if.source result
);

  logic               q_valid;
  stage_t             q_stage;
  logic               m_valid;
  stage_t             m_stage;
  logic [TOTAL_W-1:0] m_quot;
  logic               out_valid;

  logic               out_ready;
  logic               m_ready;
  logic               q_ready;

  logic [16:0]        scale_recip;
  logic [32:0]        scale_prod;
  logic [TOTAL_W-1:0] scale_q;
  logic [31:0]        mod_prod;
  logic [TOTAL_W-1:0] mod_quot;
  logic [TOTAL_W-1:0] mod_back;
  logic [TOTAL_W-1:0] rem;
  logic [SEG_W-1:0]   seg_next;
  logic [SEG_W-1:0]   seg;
  digit_t             out_digit;

  assign out_ready   = !out_valid || result.ready;
  assign m_ready     = !m_valid || out_ready;
  assign q_ready     = !q_valid || m_ready;
  assign stage_ready = q_ready;

  assign result.valid       = out_valid;
  assign result.digit_index = out_digit;
  assign result.segments_n  = seg;

  // scale by the digit's place: 1, 10, 60 or 600
  always_comb begin
    case (stage.digit)
      DIG_SEC_ONES: scale_recip = 17'd1;
      DIG_SEC_TENS: scale_recip = RECIP_10;
      DIG_MIN_ONES: scale_recip = RECIP_60;
      DIG_MIN_TENS: scale_recip = RECIP_600;
      default:      scale_recip = 17'd1;
    endcase
    scale_prod = {17'b0, stage.value} * {16'b0, scale_recip};
    case (stage.digit)
      DIG_SEC_ONES: scale_q = scale_prod[15:0];
      DIG_SEC_TENS: scale_q = {3'b0, scale_prod[31:19]};
      DIG_MIN_ONES: scale_q = {5'b0, scale_prod[31:21]};
      DIG_MIN_TENS: scale_q = {9'b0, scale_prod[32:26]};
      default:      scale_q = scale_prod[15:0];
    endcase
  end

  // quotient by 10 for ones digits, by 6 for tens digits
  always_comb begin
    if (q_stage.digit == DIG_SEC_ONES || q_stage.digit == DIG_MIN_ONES) begin
      mod_prod = {16'b0, q_stage.value} * {15'b0, RECIP_10};
      mod_quot = {3'b0, mod_prod[31:19]};
    end else begin
      mod_prod = {16'b0, q_stage.value} * {16'b0, RECIP_6};
      mod_quot = mod_prod[31:16];
    end
  end

  // remainder and segment decode
  always_comb begin
    if (m_stage.digit == DIG_SEC_ONES || m_stage.digit == DIG_MIN_ONES) begin
      mod_back = {m_quot[12:0], 3'b000} + {m_quot[14:0], 1'b0};
    end else begin
      mod_back = {m_quot[13:0], 2'b00} + {m_quot[14:0], 1'b0};
    end
    rem = m_stage.value - mod_back;
    case (m_stage.kind)
      KIND_ZERO:  seg_next = SEG_ZERO_N;
      KIND_DONE:  seg_next = done_font_n(m_stage.digit);
      KIND_COUNT: seg_next = ~(seg_font(rem[3:0])
                               | (m_stage.digit == DIG_MIN_ONES ? SEG_DP : 8'h00));
      default:    seg_next = SEG_ZERO_N;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_ready) begin
        q_valid <= stage_valid;
      end
      if (m_ready) begin
        m_valid <= q_valid;
      end
      if (out_ready) begin
        out_valid <= m_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready) begin
      q_stage.kind  <= stage.kind;
      q_stage.digit <= stage.digit;
      q_stage.value <= scale_q;
    end
    if (m_ready) begin
      m_stage <= q_stage;
      m_quot  <= mod_quot;
    end
    if (out_ready) begin
      out_digit <= m_stage.digit;
      seg       <= seg_next;
    end
  end

endmodule

### rtl/countdown_seven_segment_scanner_unit.sv
// countdown_seven_segment_scanner_unit: top level of the four-digit countdown scanner
// depends on cdss_pkg, cdss_if, cdss_cfg, cdss_front and cdss_digit
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+----------------------------------
//   item     | in        | valid / ready         | active, running, elapsed_seconds
//   result   | out       | valid / ready         | digit_index, segments_n
//   apb      | in        | psel, penable, pready | paddr, pwdata, prdata
//
// one request per cycle sustained while the result channel is not stalled; a result passes
// through the input register, the subtract, place-scale multiply and modulo multiply
// stages and the segment result register
// synchronous active-high reset clears the digit pointer and all valid flags
// a stalled result holds the pipeline; requests still enter until every stage is full

module countdown_seven_segment_scanner_unit
  import cdss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  cdss_item_if.sink         item,
  cdss_result_if.source     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [TOTAL_W-1:0] total;
  logic               stage_valid;
  logic               stage_ready;
  stage_t             stage;

  cdss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .total   (total)
  );

  cdss_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .total       (total),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage       (stage)
  );

  cdss_digit u_digit (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage       (stage),
    .result      (result)
  );

endmodule

### tb/cdss_scan_checker.sv
// cdss_scan_checker: watches the request, result and register channels of the scanner,
// predicts the digit drive per shown request and compares it with what the block returns
// depends on cdss_pkg and cdss_if
`timescale 1ns / 100ps

module cdss_scan_checker
  import cdss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  cdss_item_if              item,
  cdss_result_if            result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                pending_count,
  output int                checked_count
);

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [SEG_W-1:0]   seg_n;
  } digit_drive_t;

  digit_drive_t       expected_digits[$];
  logic [WASH_W-1:0]  wash_len;
  logic [FILL_W-1:0]  fill_len;
  logic [RINSE_W-1:0] rinse_len;
  logic [SPIN_W-1:0]  spin_len;
  logic [DIGIT_W-1:0] scan_pos;

  function automatic logic [SEG_W-1:0] glyph(int unsigned val);
    case (val)
      0: return 8'h3F;
      1: return 8'h06;
      2: return 8'h5B;
      3: return 8'h4F;
      4: return 8'h66;
      5: return 8'h6D;
      6: return 8'h7D;
      7: return 8'h27;
      8: return 8'h7F;
      default: return 8'h67;
    endcase
  endfunction

  function automatic logic [SEG_W-1:0] finish_glyph(digit_t pos);
    case (pos)
      DIG_SEC_ONES: return 8'h0F;
      DIG_SEC_TENS: return 8'h09;
      DIG_MIN_ONES: return 8'h09;
      default:      return 8'h39;
    endcase
  endfunction

  function automatic int unsigned program_length();
    int unsigned total;
    if (fill_len != 0 && rinse_len != 0) begin
      total = wash_len + 4 * fill_len + rinse_len + spin_len;
      if (total > 65535) total = 65535;
    end else begin
      total = spin_len;
    end
    return total;
  endfunction

  task automatic predict_tick(input logic act, input logic run, input logic [15:0] el);
    int unsigned total;
    int unsigned left;
    logic [SEG_W-1:0] lit;
    if (!act || (run && el[15])) return;
    if (!run) begin
      lit = glyph(0);
    end else begin
      total = program_length();
      if (el < total) begin
        left = total - el;
        case (digit_t'(scan_pos))
          DIG_SEC_ONES: lit = glyph(left % 10);
          DIG_SEC_TENS: lit = glyph((left / 10) % 6);
          DIG_MIN_ONES: lit = glyph((left / 60) % 10) | SEG_DP;
          default:      lit = glyph((left / 600) % 6);
        endcase
      end else begin
        lit = finish_glyph(digit_t'(scan_pos));
      end
    end
    expected_digits.push_back('{digit: scan_pos, seg_n: ~lit});
    scan_pos = scan_pos + 1'b1;
  endtask

  always @(posedge clk) begin : monitor
    digit_drive_t head;
    if (rst) begin
      expected_digits.delete();
      wash_len  = '0;
      fill_len  = '0;
      rinse_len = '0;
      spin_len  = '0;
      scan_pos  = '0;
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[3:2]))
          REG_WASH:  wash_len  = pwdata[WASH_W-1:0];
          REG_FILL:  fill_len  = pwdata[FILL_W-1:0];
          REG_RINSE: rinse_len = pwdata[RINSE_W-1:0];
          default:   spin_len  = pwdata[SPIN_W-1:0];
        endcase
      end
      if (result.valid && result.ready) begin
        checked_count++;
        if (expected_digits.size() == 0) begin
          $error("unexpected result: digit_index %0d segments_n 0x%02h",
                 result.digit_index, result.segments_n);
          fail_count++;
        end else begin
          head = expected_digits.pop_front();
          if (result.digit_index !== head.digit) begin
            $error("digit_index: expected %0d, got %0d", head.digit, result.digit_index);
            fail_count++;
          end
          if (result.segments_n !== head.seg_n) begin
            $error("segments_n: expected 0x%02h, got 0x%02h", head.seg_n, result.segments_n);
            fail_count++;
          end
        end
      end
      if (item.valid && item.ready)
        predict_tick(item.active, item.running, item.elapsed_seconds);
    end
    pending_count = expected_digits.size();
  end

endmodule

### tb/tb_top.sv
// tb_top: drives requests, register writes and result back-pressure into the scanner
// and reports the verdict; depends on cdss_pkg, cdss_if, cdss_scan_checker and the rtl
`timescale 1ns / 100ps

module tb_top
  import cdss_pkg::*;
();

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 118;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cdss_item_if   item_ch();
  cdss_result_if result_ch();

  int          fail_count;
  int          pending_count;
  int          checked_count;
  int          requests_sent;
  int          settings_applied;
  int          idle_cycles;
  int unsigned plan_total;
  bit          sender_quiet;
  bit          receiver_quiet;
  bit          hold_results;

  countdown_seven_segment_scanner_unit uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cdss_scan_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .item          (item_ch),
    .result        (result_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst || psel || (item_ch.valid && item_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic act, input logic run, input logic [15:0] el);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid           <= 1'b1;
    item_ch.active          <= act;
    item_ch.running         <= run;
    item_ch.elapsed_seconds <= el;
    do @(posedge clk); while (!item_ch.ready);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_count != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input int unsigned val);
    int keep;
    keep = (idx == REG_FILL) ? FILL_W : WASH_W;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // junk above the register width must be dropped
    pwdata  <= (DATA_W'($urandom()) << keep) | DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input int unsigned w, input int unsigned f,
                               input int unsigned r, input int unsigned s);
    item_ch.valid <= 1'b0;
    drain();
    write_reg(REG_WASH, w);
    write_reg(REG_FILL, f);
    write_reg(REG_RINSE, r);
    write_reg(REG_SPIN, s);
    plan_total = (f != 0 && r != 0) ? w + 4 * f + r + s : s;
    settings_applied++;
  endtask

  function automatic int unsigned pick_len(input int unsigned top_val);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return top_val;
      2, 3:    return $urandom_range(0, top_val);
      default: return $urandom_range(0, top_val / 16);
    endcase
  endfunction

  function automatic logic [15:0] pick_elapsed();
    int unsigned span;
    int aim;
    span = (plan_total > 32747) ? 32767 : plan_total + 20;
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: begin
        aim = int'(plan_total) + int'($urandom_range(0, 6)) - 3;
        if (aim < 0) aim = 0;
        if (aim > 32767) aim = 32767;
        return 16'(aim);
      end
      default: return 16'($urandom_range(0, span));
    endcase
  endfunction

  initial begin : result_sink
    int stall;
    bit held;
    held = 1'b0;
    result_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_results && !held) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = receiver_quiet ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    item_ch.valid           = 1'b0;
    item_ch.active          = 1'b0;
    item_ch.running         = 1'b0;
    item_ch.elapsed_seconds = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    requests_sent    = 0;
    settings_applied = 0;
    plan_total       = 0;
    sender_quiet     = 1'b0;
    receiver_quiet   = 1'b0;
    hold_results     = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting: zero-length program, stopped, inactive and negative elapsed
    send_request(1'b1, 1'b1, 16'd0);
    send_request(1'b1, 1'b1, 16'h7FFF);
    send_request(1'b1, 1'b0, 16'h8000);
    send_request(1'b0, 1'b1, 16'd5);
    send_request(1'b1, 1'b1, 16'hFFFF);
    send_request(1'b0, 1'b0, 16'hFFFF);
    send_request(1'b1, 1'b0, 16'd0);

    // full program, last second and end boundary
    apply_setting(100, 20, 30, 50);
    repeat (4) send_request(1'b1, 1'b1, 16'd0);
    send_request(1'b1, 1'b1, 16'd259);
    send_request(1'b1, 1'b1, 16'd260);
    send_request(1'b1, 1'b1, 16'd261);

    // longest program, minutes tens wraps
    apply_setting(16383, 4095, 16383, 16383);
    repeat (4) send_request(1'b1, 1'b1, 16'd0);
    send_request(1'b1, 1'b1, 16'h7FFF);

    // spin only when fill or rinse is zero
    apply_setting(0, 0, 16383, 16383);
    send_request(1'b1, 1'b1, 16'd16382);
    send_request(1'b1, 1'b1, 16'd16383);
    apply_setting(500, 5, 0, 0);
    send_request(1'b1, 1'b1, 16'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      apply_setting(pick_len(16383), pick_len(4095), pick_len(16383), pick_len(16383));
      sender_quiet   = (phase % 3 == 1) || (phase == 3);
      receiver_quiet = (phase % 4 == 2) || (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long result stall while requests keep coming
        if (phase == 4 && n == 30) hold_results = 1'b1;
        send_request($urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0, pick_elapsed());
      end
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    item_ch.valid <= 1'b0;
    drain();
    repeat (8) @(negedge clk);

    $display("covered %0d requests under %0d register settings, %0d digit drives checked",
             requests_sent, settings_applied, checked_count);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/cdss_pkg.sv
rtl/cdss_if.sv
rtl/cdss_cfg.sv
rtl/cdss_front.sv
rtl/cdss_digit.sv
rtl/countdown_seven_segment_scanner_unit.sv
tb/cdss_scan_checker.sv
tb/tb_top.sv
